[rtl/wes_pkg.sv]
// ----------------------------------------------------------------------------
// wes_pkg
// Shared types, constants and codes of the wave equation stencil update unit.
// ----------------------------------------------------------------------------
package wes_pkg;

	localparam int MAX_NX_DEF = 128;
	localparam int MAX_NY_DEF = 128;
	localparam int MAX_NZ_DEF = 128;

	localparam int IDX_W  = 21;
	localparam int VAL_W  = 32;
	localparam int QDEPTH = 2;

	localparam logic [1:0] DIMS_RST = 2'd3;
	localparam logic [7:0] SIZE_RST = 8'd128;

	typedef enum logic [2:0] {
		REG_DIMS,
		REG_SIZE_X,
		REG_SIZE_Y,
		REG_SIZE_Z,
		REG_W_CENTER,
		REG_W_X,
		REG_W_Y,
		REG_W_Z
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] dims;
		logic [7:0] size_x;
		logic [7:0] size_y;
		logic [7:0] size_z;
	} geo_t;

	typedef struct packed {
		logic signed [31:0] w_center;
		logic signed [31:0] w_x;
		logic signed [31:0] w_y;
		logic signed [31:0] w_z;
	} wgt_t;

	typedef struct packed {
		logic [IDX_W-1:0]   n;
		logic signed [31:0] xn;
		logic signed [32:0] sx;
		logic signed [32:0] sy;
		logic signed [32:0] sz;
		logic signed [31:0] yn;
		logic [31:0]        cn;
		logic [1:0]         d;
	} job_t;

	typedef enum logic [3:0] {
		F_IDLE,
		F_W0,
		F_W1,
		F_W2,
		F_CHK,
		F_D1,
		F_D2,
		F_RD,
		F_CP,
		F_WR
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_MUL,
		B_SUM,
		B_DIV,
		B_OUT
	} back_state_t;

endpackage

[rtl/wave_equation_stencil_update_unit.sv]
// ----------------------------------------------------------------------------
// wave_equation_stencil_update_unit
// Streaming second-order wave equation update on a 1D, 2D or 3D grid.
// ----------------------------------------------------------------------------
// Grid points enter on the s_ channel in raster order (x fastest); each
// carries x, y and coef. For every interior point one transaction leaves on
// the m_ channel with its raster index, the saturated y_new and a flag;
// boundary points produce nothing. Configuration is written through
// cfg_we/cfg_addr/cfg_wdata; the user must write it only while no point is
// in flight, which the block itself does not enforce. The front takes a
// boundary point directly and gathers the neighbours of an interior point
// with six reads through the one read port of the x plane store. The back
// uses the 64-step coefficient divider only in 1D with a nonzero coef; a
// two-entry queue sits between them.
// After reset and after any register write, the front rebuilds its grid
// position with a 22-step divider and holds s_tready low. Stores are not
// cleared. A stalled m_tready holds the output register; the back then
// stops and the queue and front fill before s_tready drops.
// ----------------------------------------------------------------------------
module wave_equation_stencil_update_unit #(
	parameter int MAX_NX = wes_pkg::MAX_NX_DEF,
	parameter int MAX_NY = wes_pkg::MAX_NY_DEF,
	parameter int MAX_NZ = wes_pkg::MAX_NZ_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // x_val, y_val, coef_val
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // point_index, y_new, zero pad
	output logic [0:0]  m_tuser    // overflow
);

	wes_pkg::geo_t geo_q;
	wes_pkg::wgt_t wgt_q;
	wes_pkg::job_t f_job, b_job;
	logic          q_push, q_full, q_valid, q_pop;
	logic [wes_pkg::IDX_W-1:0] point_index;
	logic [wes_pkg::VAL_W-1:0] y_new;
	logic          overflow;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geo_q.dims   <= wes_pkg::DIMS_RST;
			geo_q.size_x <= wes_pkg::SIZE_RST;
			geo_q.size_y <= wes_pkg::SIZE_RST;
			geo_q.size_z <= wes_pkg::SIZE_RST;
			wgt_q        <= '0;
		end else if (cfg_we) begin
			case (wes_pkg::reg_idx_t'(cfg_addr))
				wes_pkg::REG_DIMS:     geo_q.dims   <= cfg_wdata[1:0];
				wes_pkg::REG_SIZE_X:   geo_q.size_x <= cfg_wdata[7:0];
				wes_pkg::REG_SIZE_Y:   geo_q.size_y <= cfg_wdata[7:0];
				wes_pkg::REG_SIZE_Z:   geo_q.size_z <= cfg_wdata[7:0];
				wes_pkg::REG_W_CENTER: wgt_q.w_center <= cfg_wdata;
				wes_pkg::REG_W_X:      wgt_q.w_x <= cfg_wdata;
				wes_pkg::REG_W_Y:      wgt_q.w_y <= cfg_wdata;
				wes_pkg::REG_W_Z:      wgt_q.w_z <= cfg_wdata;
				default:               wgt_q <= wgt_q;
			endcase
		end
	end

	wes_front #(
		.MAX_NX (MAX_NX),
		.MAX_NY (MAX_NY),
		.MAX_NZ (MAX_NZ)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.geo      (geo_q),
		.geo_chg  (cfg_we),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (f_job)
	);

	wes_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.job_in  (f_job),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.job_out (b_job)
	);

	wes_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wgt         (wgt_q),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_job       (b_job),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.point_index (point_index),
		.y_new       (y_new),
		.overflow    (overflow)
	);

	assign m_tdata = {3'b000, y_new, point_index};
	assign m_tuser = overflow;

endmodule

[rtl/wes_ram.sv]
// ----------------------------------------------------------------------------
// wes_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wes_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/wes_div.sv]
// ----------------------------------------------------------------------------
// wes_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wes_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         busy,
	output logic         done,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);

	localparam int CNW = $clog2(W + 1);

	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [W-1:0]   rem_q;
	logic [W-1:0]   quo_q;
	logic [W-1:0]   den_q;
	logic [W:0]     r_sh;
	logic [W:0]     diff;

	assign r_sh = {rem_q, quo_q[W-1]};
	assign diff = r_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNW'(W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= r_sh[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

[rtl/wes_queue.sv]
// ----------------------------------------------------------------------------
// wes_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module wes_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  wes_pkg::job_t job_in,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output wes_pkg::job_t job_out
);

	localparam int PW = (wes_pkg::QDEPTH > 1) ? $clog2(wes_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(wes_pkg::QDEPTH + 1);

	wes_pkg::job_t  ent_q [wes_pkg::QDEPTH];
	logic [PW-1:0]  wp_q;
	logic [PW-1:0]  rp_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (cnt_q == CW'(wes_pkg::QDEPTH));
	assign valid   = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign job_out = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PW'(wes_pkg::QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == PW'(wes_pkg::QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= job_in;
		end
	end

endmodule

[rtl/wes_front.sv]
// ----------------------------------------------------------------------------
// wes_front
// Accepts grid points, tracks the raster position, classifies interior points,
// gathers the stencil neighbours from the line stores and queues jobs.
// ----------------------------------------------------------------------------
module wes_front #(
	parameter int MAX_NX = wes_pkg::MAX_NX_DEF,
	parameter int MAX_NY = wes_pkg::MAX_NY_DEF,
	parameter int MAX_NZ = wes_pkg::MAX_NZ_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  wes_pkg::geo_t geo,
	input  logic          geo_chg,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [95:0]   s_tdata,
	input  logic          q_full,
	output logic          q_push,
	output wes_pkg::job_t q_job
);

	localparam int XDEPTH = 2 * MAX_NX * MAX_NY;
	localparam int YDEPTH = MAX_NX * MAX_NY + MAX_NX;
	localparam int XAW    = $clog2(XDEPTH);
	localparam int YAW    = $clog2(YDEPTH);
	localparam int OW     = XAW + 1;
	localparam int NXW    = $clog2(MAX_NX + 1);
	localparam int NYW    = $clog2(MAX_NY + 1);
	localparam int NZW    = $clog2(MAX_NZ + 1);
	localparam int PW     = $clog2(MAX_NX * MAX_NY + 1);
	localparam int CW     = $clog2(MAX_NX * MAX_NY * MAX_NZ + 1);

	wes_pkg::front_state_t state_q, state_d;

	logic [1:0]     d_c, d_q;
	logic [NXW-1:0] nx_c, nx_q;
	logic [NYW-1:0] ny_c, ny_q;
	logic [NZW-1:0] nz_c, nz_q;
	logic [PW-1:0]  plane_q;
	logic [CW-1:0]  total_q;
	logic [PW-1:0]  lag;

	logic [CW-1:0]  c_q;
	logic [XAW-1:0] cx_q;
	logic [YAW-1:0] cy_q;
	logic [NXW-1:0] ci_q;
	logic [NYW-1:0] cj_q;
	logic [NZW-1:0] ck_q;
	logic           chg_q;

	logic signed [31:0] xv_q, yv_q;
	logic [31:0]        cv_q;
	logic               inner_q;
	logic               inner_c;
	logic [2:0]         step_q;
	logic signed [31:0] xs_q [6];
	logic signed [31:0] yn_q;
	logic [31:0]        cn_q;

	logic [OW-1:0]         off;
	logic signed [OW:0]    xt;
	logic signed [YAW+1:0] yt;
	logic [XAW-1:0]        xaddr;
	logic [YAW-1:0]        yaddr;
	logic [31:0]           x_rd, y_rd, c_rd;
	logic                  mem_we;
	logic                  accept;
	logic                  last_pt;

	logic          div_start;
	logic [CW-1:0] div_a, div_b;
	logic          div_busy, div_done;
	logic [CW-1:0] div_quo, div_rem;
	logic          ci_mid, cj_mid;
	logic [CW-1:0] n_c;

	always_comb begin
		d_c = (geo.dims == 2'd0) ? 2'd1 : geo.dims;
		if (geo.size_x < 8'd3) begin
			nx_c = NXW'(3);
		end else if (32'(geo.size_x) > MAX_NX) begin
			nx_c = NXW'(MAX_NX);
		end else begin
			nx_c = NXW'(geo.size_x);
		end
		if (d_c < 2'd2 || geo.size_y == 8'd0) begin
			ny_c = NYW'(1);
		end else if (32'(geo.size_y) > MAX_NY) begin
			ny_c = NYW'(MAX_NY);
		end else begin
			ny_c = NYW'(geo.size_y);
		end
		if (d_c != 2'd3 || geo.size_z == 8'd0) begin
			nz_c = NZW'(1);
		end else if (32'(geo.size_z) > MAX_NZ) begin
			nz_c = NZW'(MAX_NZ);
		end else begin
			nz_c = NZW'(geo.size_z);
		end
	end

	always_ff @(posedge clk) begin
		d_q     <= d_c;
		nx_q    <= nx_c;
		ny_q    <= ny_c;
		nz_q    <= nz_c;
		plane_q <= PW'(nx_q) * PW'(ny_q);
		total_q <= CW'(plane_q) * CW'(nz_q);
	end

	always_comb begin
		case (d_q)
			2'd3: lag = plane_q;
			2'd2: lag = PW'(nx_q);
			default: lag = PW'(1);
		endcase
	end

	always_comb begin
		case (step_q)
			3'd0: off = OW'(lag);
			3'd1: off = OW'(lag) + 1'b1;
			3'd2: off = OW'(lag) - 1'b1;
			3'd3: off = OW'(lag) + OW'(nx_q);
			3'd4: off = OW'(lag) - OW'(nx_q);
			default: off = OW'(plane_q) << 1;
		endcase
		xt = $signed((OW+1)'(cx_q)) - $signed((OW+1)'(off));
		if (xt < 0) begin
			xt = xt + $signed((OW+1)'(XDEPTH));
		end
		xaddr = xt[XAW-1:0];
		yt = $signed((YAW+2)'(cy_q)) - $signed((YAW+2)'(lag));
		if (yt < 0) begin
			yt = yt + $signed((YAW+2)'(YDEPTH));
		end
		yaddr = yt[YAW-1:0];
	end

	always_comb begin
		ci_mid = (ci_q >= NXW'(1)) && (({1'b0, ci_q} + 2'd2) <= {1'b0, nx_q});
		cj_mid = (cj_q >= NYW'(1)) && (({1'b0, cj_q} + 2'd2) <= {1'b0, ny_q});
		case (d_q)
			2'd3: inner_c = ci_mid && cj_mid && (ck_q >= NZW'(2));
			2'd2: inner_c = ci_mid && (cj_q >= NYW'(2));
			default: inner_c = (ci_q >= NXW'(2));
		endcase
	end

	assign last_pt = (c_q + 1'b1) >= total_q;
	assign n_c     = c_q - CW'(lag);

	always_comb begin
		state_d = state_q;
		case (state_q)
			wes_pkg::F_IDLE: begin
				if (chg_q || geo_chg) begin
					state_d = wes_pkg::F_W0;
				end else if (s_tvalid) begin
					state_d = inner_c ? wes_pkg::F_RD : wes_pkg::F_WR;
				end
			end
			wes_pkg::F_W0: state_d = wes_pkg::F_W1;
			wes_pkg::F_W1: state_d = wes_pkg::F_W2;
			wes_pkg::F_W2: state_d = wes_pkg::F_CHK;
			wes_pkg::F_CHK: begin
				state_d = (c_q >= total_q) ? wes_pkg::F_IDLE : wes_pkg::F_D1;
			end
			wes_pkg::F_D1: begin
				if (div_done) begin
					state_d = wes_pkg::F_D2;
				end
			end
			wes_pkg::F_D2: begin
				if (div_done) begin
					state_d = wes_pkg::F_IDLE;
				end
			end
			wes_pkg::F_RD: state_d = wes_pkg::F_CP;
			wes_pkg::F_CP: begin
				state_d = (step_q == 3'd5) ? wes_pkg::F_WR : wes_pkg::F_RD;
			end
			wes_pkg::F_WR: begin
				if (!inner_q || !q_full) begin
					state_d = wes_pkg::F_IDLE;
				end
			end
			default: state_d = wes_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = (state_q == wes_pkg::F_IDLE) && !chg_q && !geo_chg;
		mem_we    = (state_q == wes_pkg::F_WR) && (!inner_q || !q_full);
		q_push    = mem_we && inner_q;
		div_start = 1'b0;
		div_a     = c_q;
		div_b     = CW'(nx_q);
		case (state_q)
			wes_pkg::F_CHK: begin
				div_start = (c_q < total_q);
			end
			wes_pkg::F_D1: begin
				div_start = div_done;
				div_a     = div_quo;
				div_b     = CW'(ny_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wes_pkg::F_W0;
			chg_q   <= 1'b0;
			c_q     <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
			ci_q    <= '0;
			cj_q    <= '0;
			ck_q    <= '0;
			step_q  <= '0;
			inner_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (geo_chg) begin
				chg_q <= 1'b1;
			end else if (state_q == wes_pkg::F_W0) begin
				chg_q <= 1'b0;
			end
			case (state_q)
				wes_pkg::F_IDLE: begin
					if (accept) begin
						inner_q <= inner_c;
						step_q  <= '0;
					end
				end
				wes_pkg::F_CHK: begin
					if (c_q >= total_q) begin
						c_q  <= '0;
						cx_q <= '0;
						cy_q <= '0;
						ci_q <= '0;
						cj_q <= '0;
						ck_q <= '0;
					end
				end
				wes_pkg::F_D1: begin
					if (div_done) begin
						ci_q <= NXW'(div_rem);
					end
				end
				wes_pkg::F_D2: begin
					if (div_done) begin
						cj_q <= NYW'(div_rem);
						ck_q <= NZW'(div_quo);
					end
				end
				wes_pkg::F_CP: begin
					step_q <= step_q + 1'b1;
				end
				wes_pkg::F_WR: begin
					if (mem_we) begin
						if (last_pt) begin
							c_q  <= '0;
							cx_q <= '0;
							cy_q <= '0;
							ci_q <= '0;
							cj_q <= '0;
							ck_q <= '0;
						end else begin
							c_q  <= c_q + 1'b1;
							cx_q <= (cx_q == XAW'(XDEPTH - 1)) ? '0 : cx_q + 1'b1;
							cy_q <= (cy_q == YAW'(YDEPTH - 1)) ? '0 : cy_q + 1'b1;
							if (({1'b0, ci_q} + 1'b1) == {1'b0, nx_q}) begin
								ci_q <= '0;
								if (({1'b0, cj_q} + 1'b1) == {1'b0, ny_q}) begin
									cj_q <= '0;
									ck_q <= ck_q + 1'b1;
								end else begin
									cj_q <= cj_q + 1'b1;
								end
							end else begin
								ci_q <= ci_q + 1'b1;
							end
						end
					end
				end
				default: begin
					step_q <= step_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			xv_q <= s_tdata[31:0];
			yv_q <= s_tdata[63:32];
			cv_q <= s_tdata[95:64];
		end
		if (state_q == wes_pkg::F_CP) begin
			xs_q[step_q] <= (off == '0) ? xv_q : x_rd;
			if (step_q == 3'd0) begin
				yn_q <= y_rd;
				cn_q <= c_rd;
			end
		end
	end

	always_comb begin
		q_job.n  = wes_pkg::IDX_W'(n_c);
		q_job.xn = xs_q[0];
		q_job.sx = 33'(xs_q[1]) + 33'(xs_q[2]);
		q_job.sy = (d_q >= 2'd2) ? 33'(xs_q[3]) + 33'(xs_q[4]) : '0;
		q_job.sz = (d_q == 2'd3) ? 33'(xs_q[5]) + 33'(xv_q) : '0;
		q_job.yn = yn_q;
		q_job.cn = cn_q;
		q_job.d  = d_q;
	end

	wes_div #(
		.W(CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.busy     (div_busy),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	wes_ram #(
		.W     (32),
		.DEPTH (XDEPTH)
	) u_x_ram (
		.clk   (clk),
		.we    (mem_we && !div_busy),
		.waddr (cx_q),
		.wdata (xv_q),
		.raddr (xaddr),
		.rdata (x_rd)
	);

	wes_ram #(
		.W     (32),
		.DEPTH (YDEPTH)
	) u_y_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cy_q),
		.wdata (yv_q),
		.raddr (yaddr),
		.rdata (y_rd)
	);

	wes_ram #(
		.W     (32),
		.DEPTH (YDEPTH)
	) u_c_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cy_q),
		.wdata (cv_q),
		.raddr (yaddr),
		.rdata (c_rd)
	);

endmodule

[rtl/wes_back.sv]
// ----------------------------------------------------------------------------
// wes_back
// Evaluates the stencil sum with one shared multiplier, divides by the
// coefficient in 1D, saturates and holds the result in the output register.
// ----------------------------------------------------------------------------
module wes_back (
	input  logic          clk,
	input  logic          arst_n,
	input  wes_pkg::wgt_t wgt,
	input  logic          q_valid,
	output logic          q_pop,
	input  wes_pkg::job_t q_job,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [wes_pkg::IDX_W-1:0] point_index,
	output logic [wes_pkg::VAL_W-1:0] y_new,
	output logic          overflow
);

	wes_pkg::back_state_t state_q, state_d;

	wes_pkg::job_t      job_q;
	logic [2:0]         step_q;
	logic signed [31:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [64:0] prod_d, prod_q;
	logic signed [67:0] acc_q;
	logic signed [43:0] lsum;
	logic signed [59:0] num60;
	logic signed [63:0] num64;
	logic [63:0]        mag;
	logic signed [63:0] term_q;
	logic               zf_q;
	logic               neg_q;
	logic signed [63:0] base;
	logic signed [63:0] res;
	logic               sat;
	logic               ov_q;
	logic               load;
	logic               div_start;
	logic               div_busy, div_done;
	logic [63:0]        div_quo, div_rem;

	always_comb begin
		case (step_q)
			3'd0: begin
				mul_a = wgt.w_center;
				mul_b = {job_q.xn[31], job_q.xn};
			end
			3'd1: begin
				mul_a = wgt.w_x;
				mul_b = job_q.sx;
			end
			3'd2: begin
				mul_a = wgt.w_y;
				mul_b = job_q.sy;
			end
			3'd3: begin
				mul_a = wgt.w_z;
				mul_b = job_q.sz;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod_d = mul_a * mul_b;
	end

	always_comb begin
		lsum  = acc_q[67:24];
		num60 = {lsum, 16'h0000};
		num64 = {{4{num60[59]}}, num60};
		mag   = num64[63] ? 64'(-num64) : 64'(num64);
		base  = $signed({{31{job_q.xn[31]}}, job_q.xn, 1'b0})
			- $signed({{32{job_q.yn[31]}}, job_q.yn});
		res   = base + term_q;
		sat   = !((res[63:31] == '0) || (res[63:31] == '1));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			wes_pkg::B_IDLE: begin
				if (q_valid) begin
					state_d = wes_pkg::B_MUL;
				end
			end
			wes_pkg::B_MUL: begin
				if (step_q == 3'd4) begin
					state_d = wes_pkg::B_SUM;
				end
			end
			wes_pkg::B_SUM: begin
				if (job_q.d == 2'd1 && job_q.cn != '0) begin
					state_d = wes_pkg::B_DIV;
				end else begin
					state_d = wes_pkg::B_OUT;
				end
			end
			wes_pkg::B_DIV: begin
				if (div_done) begin
					state_d = wes_pkg::B_OUT;
				end
			end
			wes_pkg::B_OUT: begin
				if (load) begin
					state_d = wes_pkg::B_IDLE;
				end
			end
			default: state_d = wes_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_pop     = (state_q == wes_pkg::B_IDLE) && q_valid;
		div_start = (state_q == wes_pkg::B_SUM) && (job_q.d == 2'd1) && (job_q.cn != '0);
		load      = (state_q == wes_pkg::B_OUT) && (!ov_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wes_pkg::B_IDLE;
			step_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == wes_pkg::B_IDLE) begin
				step_q <= '0;
			end else if (state_q == wes_pkg::B_MUL) begin
				step_q <= step_q + 1'b1;
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			wes_pkg::B_IDLE: begin
				job_q  <= q_job;
				prod_q <= '0;
				acc_q  <= '0;
			end
			wes_pkg::B_MUL: begin
				prod_q <= prod_d;
				acc_q  <= acc_q + 68'(prod_q);
			end
			wes_pkg::B_SUM: begin
				neg_q <= num64[63];
				if (job_q.d == 2'd1) begin
					term_q <= '0;
					zf_q   <= (job_q.cn == '0);
				end else begin
					term_q <= 64'(lsum);
					zf_q   <= 1'b0;
				end
			end
			wes_pkg::B_DIV: begin
				if (div_done) begin
					term_q <= neg_q ? -$signed(div_quo) : $signed(div_quo);
				end
			end
			default: begin
				term_q <= term_q;
			end
		endcase
		if (load) begin
			point_index <= job_q.n;
			y_new       <= sat ? (res[63] ? 32'h8000_0000 : 32'h7FFF_FFFF) : res[31:0];
			overflow    <= sat || zf_q;
		end
	end

	assign m_tvalid = ov_q;

	wes_div #(
		.W(64)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag),
		.divisor  ({32'h0, job_q.cn}),
		.busy     (div_busy),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

endmodule

[tb/sv/wave_equation_stencil_update_unit_tb.sv]
// ----------------------------------------------------------------------------
// wave_equation_stencil_update_unit_tb
// Self-checking bench for the wave equation stencil update unit.
// ----------------------------------------------------------------------------
// Grid points stream in through a queue-fed driver with random idle bursts;
// a monitor compares every output transaction with a stencil predictor that
// keeps its own copy of the grid. Whole grids are sent in several 1D, 2D and
// 3D geometries with weights at the extremes and at random.
// ----------------------------------------------------------------------------
module wave_equation_stencil_update_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int XD = 2 * wes_pkg::MAX_NX_DEF * wes_pkg::MAX_NY_DEF;
	localparam int YD = wes_pkg::MAX_NX_DEF * wes_pkg::MAX_NY_DEF + wes_pkg::MAX_NX_DEF;
	localparam int WATCHDOG = 20000;

	typedef struct packed {
		logic [20:0] idx;
		logic [31:0] val;
		logic        ovf;
	} upd_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [31:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic [0:0]  m_tuser;

	wave_equation_stencil_update_unit i_dut (.*);

	logic [95:0] point_q[$];
	upd_t        update_q[$];
	int          errors;
	int          idle_cnt;
	bit          quiet;
	bit          hold_drv;

	int unsigned g_dims, g_sx, g_sy, g_sz;
	longint      g_wc, g_wx, g_wy, g_wz;
	int          grid_x[XD];
	int          grid_y[YD];
	int unsigned grid_c[YD];
	int unsigned cursor;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic longint fshift(longint v);
		return v >>> 24;
	endfunction

	function automatic longint nb(int unsigned idx, int unsigned cur, longint xv);
		if (idx == cur) return xv;
		return longint'(grid_x[idx % XD]);
	endfunction

	task automatic predict_point(logic [95:0] d);
		int unsigned dm, nx, ny, nz, pl, tot, lag, c, n, i, j, k;
		longint xv, yv, xn, yn, hi, lo, p, ls, term, res;
		int unsigned cv, cn;
		bit inner, flag;
		upd_t u;
		longint prods[7];
		int np;
		dm = g_dims == 0 ? 1 : g_dims;
		nx = g_sx < 3 ? 3 : (g_sx > 128 ? 128 : g_sx);
		ny = dm >= 2 ? (g_sy < 1 ? 1 : (g_sy > 128 ? 128 : g_sy)) : 1;
		nz = dm == 3 ? (g_sz < 1 ? 1 : (g_sz > 128 ? 128 : g_sz)) : 1;
		pl = nx * ny;
		tot = pl * nz;
		lag = dm == 3 ? pl : (dm == 2 ? nx : 1);
		c = cursor;
		xv = longint'($signed(d[31:0]));
		yv = longint'($signed(d[63:32]));
		cv = d[95:64];
		if (c >= tot) c = 0;
		if (c >= lag) begin
			n = c - lag;
			i = n % nx; j = (n / nx) % ny; k = n / pl;
			inner = i >= 1 && i + 2 <= nx;
			if (dm >= 2) inner = inner && j >= 1 && j + 2 <= ny;
			if (dm == 3) inner = inner && k >= 1 && k + 2 <= nz;
			if (inner) begin
				cn = grid_c[n % YD];
				yn = longint'(grid_y[n % YD]);
				xn = nb(n, c, xv);
				np = 3;
				prods[0] = g_wc * xn;
				prods[1] = g_wx * nb(n - 1, c, xv);
				prods[2] = g_wx * nb(n + 1, c, xv);
				if (dm >= 2) begin
					prods[3] = g_wy * nb(n - nx, c, xv);
					prods[4] = g_wy * nb(n + nx, c, xv);
					np = 5;
				end
				if (dm == 3) begin
					prods[5] = g_wz * nb(n - pl, c, xv);
					prods[6] = g_wz * nb(n + pl, c, xv);
					np = 7;
				end
				hi = 0; lo = 0;
				for (int q = 0; q < np; q++) begin
					p = fshift(prods[q]);
					hi += p;
					lo += prods[q] - p * 64'sd16777216;
				end
				ls = hi + fshift(lo);
				flag = 0;
				if (dm == 1) begin
					if (cn == 0) begin
						term = 0;
						flag = 1;
					end else
						term = (ls * 65536) / longint'({32'd0, cn});
				end else
					term = ls;
				res = -yn + 2 * xn + term;
				if (res > 64'sd2147483647) begin res = 64'sd2147483647; flag = 1; end
				if (res < -64'sd2147483648) begin res = -64'sd2147483648; flag = 1; end
				u.idx = n[20:0];
				u.val = res[31:0];
				u.ovf = flag;
				update_q.push_back(u);
			end
		end
		grid_x[c % XD] = int'(xv);
		grid_y[c % YD] = int'(yv);
		grid_c[c % YD] = cv;
		cursor = (c + 1 >= tot) ? 0 : c + 1;
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] exp_v);
		$display("mismatch %s: got %0h expected %0h", what, got, exp_v);
		errors++;
	endtask

	// driver
	int s_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata  <= '0;
			s_gap    = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_point(s_tdata);
			end
			if (!(s_tvalid && !s_tready)) begin
				if (s_gap > 0) begin
					s_gap--;
					s_tvalid <= 0;
				end else if (point_q.size() > 0 && !hold_drv) begin
					if (!quiet && $urandom_range(0, 9) == 0) begin
						s_gap = $urandom_range(0, 3);
						s_tvalid <= 0;
					end else begin
						s_tvalid <= 1;
						s_tdata  <= point_q.pop_front();
					end
				end else
					s_tvalid <= 0;
			end
		end
	end

	// monitor
	int m_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
			m_gap    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (update_q.size() == 0)
					report("unexpected", {8'd0, m_tdata}, 0);
				else begin
					upd_t e;
					e = update_q.pop_front();
					if (m_tdata[20:0] !== e.idx) report("point_index", m_tdata[20:0], e.idx);
					if (m_tdata[52:21] !== e.val) report("y_new", m_tdata[52:21], e.val);
					if (m_tuser[0] !== e.ovf) report("overflow", m_tuser, e.ovf);
				end
			end
			if (m_gap > 0) begin
				m_gap--;
				m_tready <= 0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				m_gap = $urandom_range(0, 3);
				m_tready <= 0;
			end else
				m_tready <= 1;
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cnt <= 0;
		else if (arst_n) begin
			idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= WATCHDOG) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic wr_reg(wes_pkg::reg_idx_t r, logic [31:0] v);
		@(posedge clk);
		cfg_we    <= 1;
		cfg_addr  <= r;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		case (r)
			wes_pkg::REG_DIMS:     g_dims = v[1:0];
			wes_pkg::REG_SIZE_X:   g_sx = v[7:0];
			wes_pkg::REG_SIZE_Y:   g_sy = v[7:0];
			wes_pkg::REG_SIZE_Z:   g_sz = v[7:0];
			wes_pkg::REG_W_CENTER: g_wc = longint'($signed(v));
			wes_pkg::REG_W_X:      g_wx = longint'($signed(v));
			wes_pkg::REG_W_Y:      g_wy = longint'($signed(v));
			default:               g_wz = longint'($signed(v));
		endcase
	endtask

	task automatic drain;
		while (point_q.size() > 0 || s_tvalid || update_q.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic logic [31:0] rval(int mode);
		case (mode)
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return $urandom_range(0, 32'h3ffff) - 32'h20000;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_grid(int unsigned cnt, int mode);
		logic [31:0] cf;
		for (int unsigned p = 0; p < cnt; p++) begin
			cf = ($urandom_range(0, 9) == 0) ? 32'h0 :
				(mode == 4 ? $urandom : $urandom_range(1, 32'h40000));
			point_q.push_back({cf, rval(mode < 4 ? 3 : 4),
				(mode < 3 && p % 2 == 0) ? rval(mode) : rval($urandom_range(3, 4))});
		end
	endtask

	task automatic run_grid(int dm, int sx, int sy, int sz, int mode);
		int unsigned nx, ny, nz;
		wr_reg(wes_pkg::REG_DIMS, dm);
		wr_reg(wes_pkg::REG_SIZE_X, sx);
		wr_reg(wes_pkg::REG_SIZE_Y, sy);
		wr_reg(wes_pkg::REG_SIZE_Z, sz);
		repeat (5) @(posedge clk);
		nx = sx < 3 ? 3 : (sx > 128 ? 128 : sx);
		ny = dm >= 2 ? (sy < 1 ? 1 : sy) : 1;
		nz = dm == 3 ? (sz < 1 ? 1 : sz) : 1;
		queue_grid(nx * ny * nz, mode);
		drain();
	endtask

	task automatic set_weights(int mode);
		wr_reg(wes_pkg::REG_W_CENTER, rval(mode));
		wr_reg(wes_pkg::REG_W_X, rval(mode));
		wr_reg(wes_pkg::REG_W_Y, rval(mode));
		wr_reg(wes_pkg::REG_W_Z, rval(mode));
	endtask

	initial begin
		arst_n = 0; cfg_we = 0; cfg_addr = wes_pkg::REG_DIMS; cfg_wdata = 0;
		errors = 0; idle_cnt = 0; quiet = 0; hold_drv = 0; cursor = 0;
		g_dims = 3; g_sx = 128; g_sy = 128; g_sz = 128;
		g_wc = 0; g_wx = 0; g_wy = 0; g_wz = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		repeat (100) @(posedge clk);
		// directed: extremes, dims 1 and 2, zero dims
		set_weights(0);
		run_grid(1, 5, 1, 1, 0);
		set_weights(1);
		run_grid(0, 3, 1, 1, 1);
		set_weights(3);
		run_grid(2, 4, 3, 1, 2);
		// random: mostly realistic weights, some full range
		for (int g = 0; g < 8; g++) begin
			set_weights($urandom_range(0, 5) == 0 ? 4 : 3);
			case (g % 4)
				0: run_grid(1, $urandom_range(3, 40), 1, 1, $urandom_range(3, 4));
				1: run_grid(2, $urandom_range(3, 10), $urandom_range(3, 8), 1, 3);
				2: run_grid(3, $urandom_range(3, 5), $urandom_range(3, 5),
					$urandom_range(3, 4), 3);
				default: run_grid(2, 255, 1, 1, 4);
			endcase
		end
		// hold the sender while configuring, then stop it mid-grid until every update has arrived
		hold_drv = 1;
		set_weights(3);
		wr_reg(wes_pkg::REG_DIMS, 3);
		wr_reg(wes_pkg::REG_SIZE_X, 4);
		wr_reg(wes_pkg::REG_SIZE_Y, 4);
		wr_reg(wes_pkg::REG_SIZE_Z, 4);
		repeat (5) @(posedge clk);
		queue_grid(64, 3);
		hold_drv = 0;
		repeat (60) @(posedge clk);
		hold_drv = 1;
		while (s_tvalid || update_q.size() > 0) @(posedge clk);
		hold_drv = 0;
		drain();
		quiet = 1;
		set_weights(4);
		run_grid(2, 6, 6, 1, 3);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
